>>> hdl/shader_bytecode_token_validator_core_assert.svh
// Assertion macros for the shader token validator.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef SHADER_BYTECODE_TOKEN_VALIDATOR_CORE_ASSERT_SVH
`define SHADER_BYTECODE_TOKEN_VALIDATOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SBTV_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked on every edge, reset included
`define SBTV_ASSERT_ALWAYS(lbl, ante, cons, msg) \
lbl: assert property (@(posedge i_clk) (ante) |-> (cons)) else $error(msg);

`endif

>>> hdl/sbtv_pkg.sv
// Package for the shader token validator: codes, types and the opcode table.
// No dependencies; imported by every module of the block.
package sbtv_pkg;

    localparam int CNT_W       = 24;
    localparam int QUEUE_DEPTH = 2;

    // status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_END_OK    = 4'd1;
    localparam logic [3:0] ST_BAD_TYPE  = 4'd2;
    localparam logic [3:0] ST_CMT_BIT   = 4'd3;
    localparam logic [3:0] ST_EARLY_END = 4'd4;
    localparam logic [3:0] ST_PHASE     = 4'd5;
    localparam logic [3:0] ST_INSTR_BIT = 4'd6;
    localparam logic [3:0] ST_ARG_MISM  = 4'd7;
    localparam logic [3:0] ST_SHORT     = 4'd8;
    localparam logic [3:0] ST_UNKNOWN   = 4'd9;
    localparam logic [3:0] ST_OVERRUN   = 4'd10;
    localparam logic [3:0] ST_UNEXP_END = 4'd11;

    // token kinds
    localparam logic [2:0] KIND_VERSION  = 3'd0;
    localparam logic [2:0] KIND_CMT_HDR  = 3'd1;
    localparam logic [2:0] KIND_CMT_WORD = 3'd2;
    localparam logic [2:0] KIND_INSTR    = 3'd3;
    localparam logic [2:0] KIND_ARG      = 3'd4;
    localparam logic [2:0] KIND_END      = 3'd5;
    localparam logic [2:0] KIND_PHASE    = 3'd6;
    localparam logic [2:0] KIND_REJECT   = 3'd7;

    // special token values
    localparam logic [15:0] TYPE_PIXEL  = 16'hFFFF;
    localparam logic [15:0] TYPE_VERTEX = 16'hFFFE;
    localparam logic [15:0] OP_COMMENT  = 16'hFFFE;
    localparam logic [31:0] TOK_END     = 32'h0000FFFF;
    localparam logic [31:0] TOK_PHASE   = 32'h0000FFFD;

    // argument count table
    localparam logic [15:0] OP_TABLE_SIZE = 16'd97;
    localparam logic [6:0]  ARGS_VAR      = 7'h7E;
    localparam logic [6:0]  ARGS_RSV      = 7'h7F;

    localparam logic [6:0] ARG_TABLE [0:96] = '{
        7'd0, 7'd2, 7'd3, 7'd3, 7'd4, 7'd3, 7'd2, 7'd2,
        7'd3, 7'd3, 7'd3, 7'd3, 7'd3, 7'd3, 7'd2, 7'd2,
        7'd2, 7'd3, 7'd4, 7'd2, 7'd3, 7'd3, 7'd3, 7'd3,
        7'd3, 7'd1, 7'd2, 7'd2, 7'd0, 7'd0, 7'd1, ARGS_VAR,
        7'd3, 7'd3, 7'd4, 7'd2, 7'd2, 7'd4, 7'd1, 7'd0,
        7'd1, 7'd2, 7'd0, 7'd0, 7'd0, 7'd2, 7'd2, 7'd2,
        7'd5, ARGS_RSV, ARGS_RSV, ARGS_RSV, ARGS_RSV, ARGS_RSV, ARGS_RSV, ARGS_RSV,
        ARGS_RSV, ARGS_RSV, ARGS_RSV, ARGS_RSV, ARGS_RSV, ARGS_RSV, ARGS_RSV, ARGS_RSV,
        ARGS_VAR, 7'd1, ARGS_VAR, 7'd2, 7'd2, 7'd2, 7'd2, 7'd2,
        7'd2, 7'd2, 7'd2, ARGS_RSV, 7'd3, 7'd2, 7'd2, 7'd2,
        7'd4, 7'd5, 7'd2, 7'd2, 7'd2, 7'd2, 7'd2, 7'd1,
        7'd4, 7'd3, 7'd4, 7'd2, 7'd2, 7'd5, 7'd3, 7'd3,
        7'd1
    };

    // classified token, front to back
    typedef struct packed {
        logic [31:0] tok;
        logic        is_comment;
        logic        is_end;
        logic        is_phase;
        logic        unknown;
        logic        is_var;
        logic [2:0]  need;
        logic        type_ok;
        logic        type_vtx;
    } t_cls;

    // one result
    typedef struct packed {
        logic [3:0]  status;
        logic [2:0]  token_kind;
        logic [15:0] opcode;
        logic [3:0]  length_field;
        logic        is_vertex;
        logic [7:0]  version_major;
        logic [7:0]  version_minor;
        logic        coissue;
        logic        predicated;
        logic [7:0]  control_bits;
        logic [31:0] payload_word;
        logic        stream_done;
    } t_result;

endpackage

>>> hdl/shader_bytecode_token_validator_core.sv
// Shader token stream validator, top level.
// Input queue side: push / full carry one 32-bit token per request,
//   accepted at a clock edge with push high and full low.
// Result queue side: empty / pop; the oldest result sits on the o_ ports
//   while empty is low and leaves at an edge with pop high.
// Configuration: i_cfg_we writes i_cfg_wdata (total_tokens, buffer length in
//   words); it is sampled at the next version token.
// Path: a pushed token waits in the request queue; the back end writes its result
//   into the result queue, whose head drives the result ports.
// Throughput: one token per cycle while the result queue has room, set by the parse
//   state update in the back end; the classify stage and the state update are split by a
//   two-entry request queue, and results wait in a two-entry result queue.
// Every token yields exactly one result. When the receiver stalls, the result
//   queue fills, the back end holds, then the request queue fills and full
//   rises; nothing is lost.
// Reset (synchronous, active low): both queues empty, parser expects a version
//   token, total_tokens cleared to zero.
// Depends on sbtv_pkg, sbtv_front, sbtv_queue, sbtv_back and the assert header.
module shader_bytecode_token_validator_core
    import sbtv_pkg::*;
#(
    parameter int COUNT_WIDTH = CNT_W,
    parameter int DEPTH       = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_token_word,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_status,
    output logic [2:0]  o_token_kind,
    output logic [15:0] o_opcode,
    output logic [3:0]  o_length_field,
    output logic        o_is_vertex,
    output logic [7:0]  o_version_major,
    output logic [7:0]  o_version_minor,
    output logic        o_coissue,
    output logic        o_predicated,
    output logic [7:0]  o_control_bits,
    output logic [31:0] o_payload_word,
    output logic        o_stream_done
);

    `include "shader_bytecode_token_validator_core_assert.svh"

    t_cls    w_cls_in, w_cls_head;
    t_result w_res_in, w_res_head;
    logic    w_mid_empty, w_mid_pop, w_out_full, w_out_push;

    // classify incoming tokens
    sbtv_front u_front (
        .i_token_word (i_token_word),
        .o_cls        (w_cls_in)
    );

    // request queue between front and back
    sbtv_queue #(
        .WIDTH ($bits(t_cls)),
        .DEPTH (DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (w_cls_in),
        .o_full  (full),
        .i_pop   (w_mid_pop),
        .o_rdata (w_cls_head),
        .o_empty (w_mid_empty)
    );

    // parse state machine
    sbtv_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cls       (w_cls_head),
        .i_mid_empty (w_mid_empty),
        .o_mid_pop   (w_mid_pop),
        .i_out_full  (w_out_full),
        .o_out_push  (w_out_push),
        .o_result    (w_res_in)
    );

    // result queue
    sbtv_queue #(
        .WIDTH ($bits(t_result)),
        .DEPTH (DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_wdata (w_res_in),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_rdata (w_res_head),
        .o_empty (empty)
    );

    // result fields
    assign o_status        = w_res_head.status;
    assign o_token_kind    = w_res_head.token_kind;
    assign o_opcode        = w_res_head.opcode;
    assign o_length_field  = w_res_head.length_field;
    assign o_is_vertex     = w_res_head.is_vertex;
    assign o_version_major = w_res_head.version_major;
    assign o_version_minor = w_res_head.version_minor;
    assign o_coissue       = w_res_head.coissue;
    assign o_predicated    = w_res_head.predicated;
    assign o_control_bits  = w_res_head.control_bits;
    assign o_payload_word  = w_res_head.payload_word;
    assign o_stream_done   = w_res_head.stream_done;

    // checks: a closed stream always carries a non-ok status and vice versa
    `SBTV_ASSERT_NOW(a_done_vs_status, !empty, o_stream_done == (o_status != ST_OK), "stream_done disagrees with status")
    // an overrun is always a rejected, closing item
    `SBTV_ASSERT_NOW(a_overrun_kind, !empty && (o_status == ST_OVERRUN), (o_token_kind == KIND_REJECT) && o_stream_done, "overrun result not rejected")
    // both queues come out of reset empty
    `SBTV_ASSERT_ALWAYS(a_reset_empty, i_rst_n && $past(!i_rst_n), empty && !full, "queues not empty after reset")

endmodule

>>> hdl/sbtv_front.sv
// Front end: decodes a raw token into a classified request.
// Depends on sbtv_pkg (opcode table, t_cls).
module sbtv_front
    import sbtv_pkg::*;
(
    input  logic [31:0] i_token_word,
    output t_cls        o_cls
);

    logic [15:0] w_op;
    logic [6:0]  w_tbl;

    // opcode table lookup; anything past the table is reserved
    always_comb begin
        w_op  = i_token_word[15:0];
        w_tbl = (w_op < OP_TABLE_SIZE) ? ARG_TABLE[w_op[6:0]] : ARGS_RSV;
    end

    // token classification
    always_comb begin
        o_cls.tok        = i_token_word;
        o_cls.is_comment = (w_op == OP_COMMENT);
        o_cls.is_end     = (i_token_word == TOK_END);
        o_cls.is_phase   = (i_token_word == TOK_PHASE);
        o_cls.unknown    = (w_tbl == ARGS_RSV);
        o_cls.is_var     = (w_tbl == ARGS_VAR);
        o_cls.need       = w_tbl[2:0];
        o_cls.type_ok    = (i_token_word[31:16] == TYPE_PIXEL) ||
                           (i_token_word[31:16] == TYPE_VERTEX);
        o_cls.type_vtx   = (i_token_word[31:16] == TYPE_VERTEX);
    end

endmodule

>>> hdl/sbtv_queue.sv
// Small first-in first-out queue of generic width.
// Depends on sbtv_pkg for the default depth.
module sbtv_queue
    import sbtv_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rdata   = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

>>> hdl/sbtv_back.sv
// Back end: parse state machine, one classified request per cycle while a request waits and the result queue has room.
// Depends on sbtv_pkg (codes, t_cls, t_result).
module sbtv_back
    import sbtv_pkg::*;
#(
    parameter int COUNT_WIDTH = CNT_W
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata,
    input  t_cls        i_cls,
    input  logic        i_mid_empty,
    output logic        o_mid_pop,
    input  logic        i_out_full,
    output logic        o_out_push,
    output t_result     o_result
);

    localparam logic [2:0] MODE_VERSION = 3'd0;
    localparam logic [2:0] MODE_NORMAL  = 3'd1;
    localparam logic [2:0] MODE_SKIP_CM = 3'd2;
    localparam logic [2:0] MODE_SKIP_AR = 3'd3;
    localparam logic [2:0] MODE_DONE    = 3'd4;

    logic [23:0]            r_total;
    logic [2:0]             r_mode, n_mode;
    logic [COUNT_WIDTH-1:0] r_rem, n_rem;
    logic [15:0]            r_skip, n_skip;
    logic                   r_vflag, n_vflag;
    logic [COUNT_WIDTH-1:0] w_load;
    logic                   w_go;
    logic [3:0]             w_len;
    t_result                w_res;

    assign w_go       = !i_mid_empty && !i_out_full;
    assign o_mid_pop  = w_go;
    assign o_out_push = w_go;
    assign o_result   = w_res;
    assign w_load     = COUNT_WIDTH'(r_total);
    assign w_len      = i_cls.tok[27:24];

    // next state and result for the request at the queue head
    always_comb begin
        n_mode  = r_mode;
        n_rem   = r_rem;
        n_skip  = r_skip;
        n_vflag = r_vflag;
        w_res   = '0;
        if (w_go) begin
            unique case (r_mode)
                MODE_VERSION: begin
                    n_rem = w_load;
                    if (w_load == '0) begin
                        w_res.status     = ST_UNEXP_END;
                        w_res.token_kind = KIND_REJECT;
                        n_mode           = MODE_DONE;
                    end else begin
                        w_res.version_major = i_cls.tok[15:8];
                        w_res.version_minor = i_cls.tok[7:0];
                        w_res.token_kind    = KIND_VERSION;
                        if (i_cls.type_ok) begin
                            n_vflag      = i_cls.type_vtx;
                            w_res.status = ST_OK;
                            n_rem        = w_load - COUNT_WIDTH'(1);
                            n_mode       = MODE_NORMAL;
                        end else begin
                            w_res.status = ST_BAD_TYPE;
                            n_mode       = MODE_DONE;
                        end
                    end
                end
                MODE_SKIP_CM, MODE_SKIP_AR: begin
                    if (r_rem == '0) begin
                        w_res.status     = ST_UNEXP_END;
                        w_res.token_kind = KIND_REJECT;
                        n_mode           = MODE_DONE;
                    end else begin
                        w_res.status       = ST_OK;
                        w_res.token_kind   = (r_mode == MODE_SKIP_CM) ? KIND_CMT_WORD
                                                                      : KIND_ARG;
                        w_res.payload_word = i_cls.tok;
                        n_rem              = r_rem - COUNT_WIDTH'(1);
                        n_skip             = r_skip - 16'd1;
                        if (r_skip == 16'd1) begin
                            n_mode = MODE_NORMAL;
                        end
                    end
                end
                MODE_NORMAL: begin
                    priority if (r_rem == '0) begin
                        w_res.status     = ST_UNEXP_END;
                        w_res.token_kind = KIND_REJECT;
                        n_mode           = MODE_DONE;
                    end else if (i_cls.is_comment) begin
                        w_res.token_kind = KIND_CMT_HDR;
                        if (i_cls.tok[31]) begin
                            w_res.status = ST_CMT_BIT;
                            n_mode       = MODE_DONE;
                        end else begin
                            w_res.status = ST_OK;
                            n_rem        = r_rem - COUNT_WIDTH'(1);
                            n_skip       = i_cls.tok[31:16];
                            if (i_cls.tok[31:16] != 16'd0) begin
                                n_mode = MODE_SKIP_CM;
                            end
                        end
                    end else if (i_cls.is_end) begin
                        w_res.token_kind = KIND_END;
                        if (r_rem != COUNT_WIDTH'(1)) begin
                            w_res.status = ST_EARLY_END;
                        end else begin
                            w_res.status = ST_END_OK;
                            n_rem        = '0;
                        end
                        n_mode = MODE_DONE;
                    end else if (i_cls.is_phase) begin
                        w_res.status     = ST_PHASE;
                        w_res.token_kind = KIND_PHASE;
                        n_mode           = MODE_DONE;
                    end else if (i_cls.unknown) begin
                        w_res.status     = ST_UNKNOWN;
                        w_res.token_kind = KIND_REJECT;
                        n_mode           = MODE_DONE;
                    end else begin
                        w_res.opcode       = i_cls.tok[15:0];
                        w_res.length_field = w_len;
                        w_res.coissue      = i_cls.tok[30];
                        w_res.predicated   = i_cls.tok[28];
                        w_res.control_bits = i_cls.tok[23:16];
                        w_res.token_kind   = KIND_INSTR;
                        priority if (i_cls.tok[31]) begin
                            w_res.status = ST_INSTR_BIT;
                            n_mode       = MODE_DONE;
                        end else if (!i_cls.is_var && ({1'b0, i_cls.need} != w_len)) begin
                            w_res.status = ST_ARG_MISM;
                            n_mode       = MODE_DONE;
                        end else if (!i_cls.is_var &&
                                     (r_rem <= COUNT_WIDTH'(i_cls.need))) begin
                            w_res.status = ST_SHORT;
                            n_mode       = MODE_DONE;
                        end else begin
                            w_res.status = ST_OK;
                            n_rem        = r_rem - COUNT_WIDTH'(1);
                            n_skip       = {12'd0, w_len};
                            if (w_len != 4'd0) begin
                                n_mode = MODE_SKIP_AR;
                            end
                        end
                    end
                end
                default: begin
                    w_res.status     = ST_OVERRUN;
                    w_res.token_kind = KIND_REJECT;
                    n_mode           = MODE_DONE;
                end
            endcase
            w_res.is_vertex   = n_vflag;
            w_res.stream_done = (n_mode == MODE_DONE);
        end
    end

    // parse state and configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_mode  <= MODE_VERSION;
            r_rem   <= '0;
            r_skip  <= '0;
            r_vflag <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
            r_mode  <= n_mode;
            r_rem   <= n_rem;
            r_skip  <= n_skip;
            r_vflag <= n_vflag;
        end
    end

endmodule
